// ===== sv/length_prefixed_frame_receiver_unit_macros.svh =====
// Assertion macros shared by the frame receiver modules.
`ifndef LENGTH_PREFIXED_FRAME_RECEIVER_UNIT_MACROS_SVH
`define LENGTH_PREFIXED_FRAME_RECEIVER_UNIT_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define LPFR_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define LPFR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/lpfr_pkg.sv =====
// Types and constants of the length-prefixed frame receiver.
package lpfr_pkg;

  // Input transaction: a received byte or a millisecond tick
  typedef struct packed {
    logic       func;
    logic [7:0] rx_byte;
  } in_item_t;

  // Output transaction: one byte of an accepted frame
  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
    logic [2:0] command_slot;
  } out_item_t;

  // Input function codes
  localparam logic FUNC_BYTE = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  // Register map
  localparam int unsigned CFG_ADDR_W = 4;
  typedef enum logic [1:0] {
    REG_GAP_TICKS     = 2'd0,
    REG_HEADER_VALUE  = 2'd1,
    REG_EXCLUDED_TYPE = 2'd2,
    REG_UNUSED        = 2'd3
  } reg_idx_t;

  localparam logic [7:0] GAP_TICKS_RST     = 8'd10;
  localparam logic [7:0] HEADER_VALUE_RST  = 8'hA0;
  localparam logic [7:0] EXCLUDED_TYPE_RST = 8'h05;

  // Fixed byte positions inside a frame
  localparam int unsigned POS_HEADER = 0;
  localparam int unsigned POS_LEN    = 1;
  localparam int unsigned POS_TYPE   = 3;
  // Fill count must exceed this before a check
  localparam int unsigned MIN_FILL   = 5;
  // Checksum sits at length + this offset
  localparam logic [8:0]  CSUM_OFS   = 9'd2;

  typedef struct packed {
    logic [7:0] gap_ticks;
    logic [7:0] header_value;
    logic [7:0] excluded_type;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SUM_RD,
    ST_SUM_ACC,
    ST_EMIT_RD,
    ST_EMIT_PUT
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic accept_byte;
    logic accept_tick;
    logic sum_start;
    logic sum_rd;
    logic sum_step;
    logic chk_pass;
    logic chk_fail;
    logic emit_start;
    logic emit_rd;
    logic emit_put;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic frame_ready;
    logic at_end;
    logic sum_match;
    logic keep_frame;
    logic out_free;
  } status_t;

endpackage

// ===== sv/lpfr_regs.sv =====
// Configuration register file with APB-style access.
module lpfr_regs (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_psel,
  input  logic                                 cfg_penable,
  input  logic                                 cfg_pwrite,
  input  logic [lpfr_pkg::CFG_ADDR_W-1:0]      cfg_paddr,
  input  logic [31:0]                          cfg_pwdata,
  output logic [31:0]                          cfg_prdata,
  output logic                                 cfg_pready,
  output lpfr_pkg::cfg_t                       cfg
);
  import lpfr_pkg::*;

  logic [7:0] gap_ticks_r;
  logic [7:0] header_value_r;
  logic [7:0] excluded_type_r;
  reg_idx_t   reg_idx;
  logic       wr_en;

  assign cfg_pready = 1'b1;
  assign reg_idx    = reg_idx_t'(cfg_paddr[3:2]);
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  // Write on the access phase of a write transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_ticks_r     <= GAP_TICKS_RST;
      header_value_r  <= HEADER_VALUE_RST;
      excluded_type_r <= EXCLUDED_TYPE_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_GAP_TICKS:     gap_ticks_r     <= cfg_pwdata[7:0];
        REG_HEADER_VALUE:  header_value_r  <= cfg_pwdata[7:0];
        REG_EXCLUDED_TYPE: excluded_type_r <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (reg_idx)
      REG_GAP_TICKS:     cfg_prdata = {24'd0, gap_ticks_r};
      REG_HEADER_VALUE:  cfg_prdata = {24'd0, header_value_r};
      REG_EXCLUDED_TYPE: cfg_prdata = {24'd0, excluded_type_r};
      default:           cfg_prdata = 32'd0;
    endcase
  end

  assign cfg.gap_ticks     = gap_ticks_r;
  assign cfg.header_value  = header_value_r;
  assign cfg.excluded_type = excluded_type_r;

endmodule

// ===== sv/lpfr_ctrl.sv =====
// Controller state machine: accepts transactions and sequences check and emission.
`include "length_prefixed_frame_receiver_unit_macros.svh"
module lpfr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_func,
  output logic              in_stall,
  input  lpfr_pkg::status_t sts,
  output lpfr_pkg::cmd_t    cmd
);
  import lpfr_pkg::*;

  state_t state_r;
  state_t state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (in_func == FUNC_TICK) begin
            cmd.accept_tick = 1'b1;
          end else begin
            cmd.accept_byte = 1'b1;
            state_nxt       = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (sts.frame_ready) begin
          cmd.sum_start = 1'b1;
          state_nxt     = ST_SUM_RD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SUM_RD: begin
        cmd.sum_rd = 1'b1;
        state_nxt  = ST_SUM_ACC;
      end
      ST_SUM_ACC: begin
        if (!sts.at_end) begin
          cmd.sum_step = 1'b1;
          state_nxt    = ST_SUM_RD;
        end else if (!sts.sum_match) begin
          cmd.chk_fail = 1'b1;
          state_nxt    = ST_IDLE;
        end else begin
          cmd.chk_pass = 1'b1;
          if (sts.keep_frame) begin
            cmd.emit_start = 1'b1;
            state_nxt      = ST_EMIT_RD;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_EMIT_RD: begin
        cmd.emit_rd = 1'b1;
        state_nxt   = ST_EMIT_PUT;
      end
      ST_EMIT_PUT: begin
        if (sts.out_free) begin
          cmd.emit_put = 1'b1;
          state_nxt    = sts.at_end ? ST_IDLE : ST_EMIT_RD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // A byte transaction always leads to a frame check
  `LPFR_ASSERT_NEXT(a_byte_to_check, clk, rst_n,
    (state_r == ST_IDLE) && in_valid && (in_func == FUNC_BYTE),
    state_r == ST_CHECK, "byte transaction did not enter frame check")

endmodule

// ===== sv/lpfr_dp.sv =====
// Datapath: frame store, fill count, gap timer, checksum walk and output register.
`include "length_prefixed_frame_receiver_unit_macros.svh"
module lpfr_dp #(
  parameter int unsigned FRAME_BYTES = 32,
  parameter int unsigned CMD_SLOTS   = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  lpfr_pkg::cfg_t      cfg,
  input  logic [7:0]          in_rx_byte,
  input  lpfr_pkg::cmd_t      cmd,
  output lpfr_pkg::status_t   sts,
  output logic                out_valid,
  input  logic                out_stall,
  output lpfr_pkg::out_item_t out_data
);
  import lpfr_pkg::*;

  localparam int unsigned AW = $clog2(FRAME_BYTES);
  localparam int unsigned SW = (CMD_SLOTS > 1) ? $clog2(CMD_SLOTS) : 1;

  logic [7:0]    mem [FRAME_BYTES];
  logic [7:0]    rdata_r;
  logic [AW-1:0] fill_r;
  logic [AW-1:0] fill_nxt;
  logic [AW-1:0] wr_idx;
  logic [7:0]    timer_r;
  logic [SW-1:0] slot_r;
  logic [AW-1:0] idx_r;
  logic [7:0]    sum_r;
  logic [7:0]    byte0_r;
  logic [7:0]    len_r;
  logic [7:0]    type_r;
  logic          out_valid_r;
  out_item_t     out_data_r;
  logic          rd_en;

  // Write position: restart the frame when the gap timer has run out
  assign wr_idx   = (timer_r == 8'd0) ? '0 : fill_r;
  assign fill_nxt = (wr_idx == AW'(FRAME_BYTES - 1)) ? wr_idx : wr_idx + 1'b1;
  assign rd_en    = cmd.sum_rd | cmd.emit_rd;

  // Frame store
  always_ff @(posedge clk) begin
    if (cmd.accept_byte) begin
      mem[wr_idx] <= in_rx_byte;
    end
    if (rd_en) begin
      rdata_r <= mem[idx_r];
    end
  end

  // Keep copies of the header, length and type bytes
  always_ff @(posedge clk) begin
    if (cmd.accept_byte) begin
      if (wr_idx == AW'(POS_HEADER)) byte0_r <= in_rx_byte;
      if (wr_idx == AW'(POS_LEN))    len_r   <= in_rx_byte;
      if (wr_idx == AW'(POS_TYPE))   type_r  <= in_rx_byte;
    end
  end

  // Fill count, gap timer and slot pointer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r  <= '0;
      timer_r <= 8'd0;
      slot_r  <= '0;
    end else begin
      if (cmd.accept_byte) begin
        fill_r  <= fill_nxt;
        timer_r <= cfg.gap_ticks;
      end else if (cmd.accept_tick) begin
        if (timer_r != 8'd0) timer_r <= timer_r - 8'd1;
      end else if (cmd.chk_fail) begin
        fill_r <= '0;
      end else if (cmd.chk_pass) begin
        timer_r <= 8'd0;
      end
      if (cmd.emit_put && sts.at_end) begin
        slot_r <= (slot_r == SW'(CMD_SLOTS - 1)) ? '0 : slot_r + 1'b1;
      end
    end
  end

  // Walk index and running checksum
  always_ff @(posedge clk) begin
    if (cmd.sum_start) begin
      idx_r <= AW'(POS_LEN);
      sum_r <= 8'd0;
    end else if (cmd.sum_step) begin
      idx_r <= idx_r + 1'b1;
      sum_r <= sum_r + rdata_r;
    end else if (cmd.emit_start) begin
      idx_r <= '0;
    end else if (cmd.emit_put) begin
      idx_r <= idx_r + 1'b1;
    end
  end

  // Output register: load a frame byte, drop valid once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_put) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_put) begin
      out_data_r.frame_byte   <= rdata_r;
      out_data_r.last_byte    <= sts.at_end;
      out_data_r.command_slot <= 3'(slot_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Status toward the controller
  assign sts.frame_ready = (byte0_r == cfg.header_value) && (9'(fill_r) > 9'(MIN_FILL))
                           && (9'(fill_r) > ({1'b0, len_r} + CSUM_OFS));
  assign sts.at_end      = (9'(idx_r) == ({1'b0, len_r} + CSUM_OFS));
  assign sts.sum_match   = (sum_r == rdata_r);
  assign sts.keep_frame  = (type_r != cfg.excluded_type);
  assign sts.out_free    = !out_valid_r || !out_stall;

  `LPFR_ASSERT_SAME(a_no_overwrite, clk, rst_n, cmd.emit_put,
    !out_valid_r || !out_stall, "pending output overwritten")
  `LPFR_ASSERT_NEXT(a_fail_restarts, clk, rst_n, cmd.chk_fail,
    fill_r == '0, "checksum mismatch did not restart the fill count")
  `LPFR_ASSERT_NEXT(a_pass_ends_frame, clk, rst_n, cmd.chk_pass,
    timer_r == 8'd0, "accepted frame did not clear the gap timer")

endmodule

// ===== sv/length_prefixed_frame_receiver_unit.sv =====
// Top level of the length-prefixed frame receiver.
// Usage:
//   in_*  : one transaction per byte or per 1 ms tick (in_data.func selects).
//           in_stall is low only while the block is idle.
//   out_* : frame bytes of accepted frames not of excluded_type, in order,
//           last_byte on the final one, tagged with the command slot number.
//   cfg_* : APB-style registers at 0x0 gap_ticks, 0x4 header_value,
//           0x8 excluded_type; pready is always high.
// Sequencing (len = length byte of the frame): a tick is taken while idle;
//   every byte passes through the frame check state. A byte that completes
//   a checkable frame starts the checksum walk, one store read per byte from
//   the length byte to the checksum at len+2, summing all but the checksum;
//   a matching frame that is kept is then emitted, one store read and one
//   output load per byte, each load waiting while a stalled output is held.
//   The single-port frame store read paces both walks.
// Reset clears the fill count, gap timer, slot pointer and output valid and
// loads the register defaults; the store holds no data until written.
// A stalled output holds its transaction and the emission waits; the input
// stays stalled until the last frame byte is loaded into the output register.
module length_prefixed_frame_receiver_unit #(
  parameter int unsigned FRAME_BYTES = 32,
  parameter int unsigned CMD_SLOTS   = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  lpfr_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output lpfr_pkg::out_item_t             out_data,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [lpfr_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]                     cfg_pwdata,
  output logic [31:0]                     cfg_prdata,
  output logic                            cfg_pready
);
  import lpfr_pkg::*;

  cfg_t    cfg;
  cmd_t    cmd;
  status_t sts;

  lpfr_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  lpfr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_data.func),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  lpfr_dp #(
    .FRAME_BYTES (FRAME_BYTES),
    .CMD_SLOTS   (CMD_SLOTS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_rx_byte (in_data.rx_byte),
    .cmd        (cmd),
    .sts        (sts),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule
